// ----- rtl/dtdn_pkg.sv -----
// ----------------------------------------------------------------------------
// dtdn_pkg
// Widths, month tables and the divide-by-25 constants shared by the
// date to day number pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dtdn_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned DNUM_W  = 22;

  // floor(q / 25) == (q * 1311) >> 15 for every 12-bit q
  localparam int unsigned DIV25_IN_W  = 12;
  localparam int unsigned DIV25_OUT_W = 8;
  localparam int unsigned DIV25_MUL   = 1311;
  localparam int unsigned DIV25_SHIFT = 15;
  localparam int unsigned DIV25_PROD_W = DIV25_IN_W + 11;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] FEB_LEAP_DAYS = 5'd29;
  localparam logic [8:0]       DAYS_PER_YEAR = 9'd365;

  // length of each month in a common year, 0 for codes that are no month
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] r;
    case (m)
      4'd1:    r = 5'd31;
      4'd2:    r = 5'd28;
      4'd3:    r = 5'd31;
      4'd4:    r = 5'd30;
      4'd5:    r = 5'd31;
      4'd6:    r = 5'd30;
      4'd7:    r = 5'd31;
      4'd8:    r = 5'd31;
      4'd9:    r = 5'd30;
      4'd10:   r = 5'd31;
      4'd11:   r = 5'd30;
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] r;
    case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dtdn_date_if.sv -----
// ----------------------------------------------------------------------------
// dtdn_date_if
// Request channel: one calendar date per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtdn_date_if
  import dtdn_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;

  modport source (output valid, day, month, year, input ready);
  modport sink   (input valid, day, month, year, output ready);
endinterface

`default_nettype wire

// ----- rtl/dtdn_result_if.sv -----
// ----------------------------------------------------------------------------
// dtdn_result_if
// Result channel: validity, leap flag, month length, ordinal and serial day.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtdn_result_if
  import dtdn_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              valid_res;
  logic              leap_year;
  logic [DAY_W-1:0]  month_length;
  logic [DOY_W-1:0]  day_of_year;
  logic [DNUM_W-1:0] day_number;

  modport source (output valid, valid_res, leap_year, month_length, day_of_year,
                  day_number, input ready);
  modport sink   (input valid, valid_res, leap_year, month_length, day_of_year,
                  day_number, output ready);
endinterface

`default_nettype wire

// ----- rtl/dtdn_div25.sv -----
// ----------------------------------------------------------------------------
// dtdn_div25
// Divide a 12-bit value by 25 with a reciprocal multiply and a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdn_div25
  import dtdn_pkg::*;
(
  input  wire logic [DIV25_IN_W-1:0]  num,
  output logic      [DIV25_OUT_W-1:0] quo
);

  logic [DIV25_PROD_W-1:0] prod;

  assign prod = DIV25_PROD_W'(num) * DIV25_PROD_W'(DIV25_MUL);
  assign quo  = prod[DIV25_SHIFT +: DIV25_OUT_W];

endmodule

`default_nettype wire

// ----- rtl/date_to_day_number_top.sv -----
// ----------------------------------------------------------------------------
// date_to_day_number_top
// Gregorian date to leap flag, month length, day of year and serial day
// number (1/1/1 is day 1).
//
// Usage:
//   date_in  (sink)   : day, month, year; a request is taken when valid and
//                       ready are both high.
//   day_out  (source) : valid_res, leap_year, month_length, day_of_year,
//                       day_number; one result per request, in order.
//   A request passes the input register, the divide-by-25 stage, the
//   leap/table/multiply-by-365 stage and the final add into the output
//   register. Throughput is one request per cycle while day_out is not stalled.
//   A date is invalid when a field is zero, the month exceeds 12, the year
//   exceeds YEAR_MAX or the day does not fit the month; its length, ordinal
//   and serial fields are then zero. leap_year follows the year field always.
//   Reset (rst, synchronous) empties the pipeline; no result is pending.
//   When day_out.ready is low with a result waiting, the whole pipeline
//   holds and date_in.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module date_to_day_number_top
  import dtdn_pkg::*;
#(
  parameter int unsigned YEAR_MAX = 9999
) (
  input  wire logic      clk,
  input  wire logic      rst,
  dtdn_date_if.sink      date_in,
  dtdn_result_if.source  day_out
);

  localparam logic [16:0] YEAR_LIMIT = 17'(YEAR_MAX);

  logic adv;

  // stage 1: input register
  logic               s1_vld;
  logic [DAY_W-1:0]   s1_day;
  logic [MONTH_W-1:0] s1_month;
  logic [YEAR_W-1:0]  s1_year;

  // stage 2: divides and table reads
  logic               s2_vld;
  logic [DAY_W-1:0]   s2_day;
  logic [MONTH_W-1:0] s2_month;
  logic [YEAR_W-1:0]  s2_year;
  logic [YEAR_W-1:0]  s2_prev;
  logic [DIV25_OUT_W-1:0] s2_p100, s2_p400, s2_y100, s2_y400;
  logic [DAY_W-1:0]   s2_mlen_base;
  logic [DOY_W-1:0]   s2_doy_base;
  logic               s2_fields_ok;

  // stage 3: leap, validity, ordinal day, multiply by 365
  logic               s3_vld;
  logic               s3_ok;
  logic               s3_leap;
  logic [DAY_W-1:0]   s3_mlen;
  logic [DOY_W-1:0]   s3_doy;
  logic [DNUM_W-1:0]  s3_p365;
  logic [12:0]        s3_corr;

  // output register
  logic               out_vld;
  logic               out_ok;
  logic               out_leap;
  logic [DAY_W-1:0]   out_mlen;
  logic [DOY_W-1:0]   out_doy;
  logic [DNUM_W-1:0]  out_dnum;

  assign adv           = !out_vld || day_out.ready;
  assign date_in.ready = adv;

  // ---------------- stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= date_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_day   <= date_in.day;
      s1_month <= date_in.month;
      s1_year  <= date_in.year;
    end
  end

  // ---------------- stage 2
  logic [YEAR_W-1:0]      prev_c;
  logic [DIV25_OUT_W-1:0] p100_c, p400_c, y100_c, y400_c;
  logic                   fields_ok_c;

  assign prev_c = s1_year - YEAR_W'(1);

  // x/100 = (x/4)/25, x/400 = (x/16)/25
  dtdn_div25 u_div_p100 (.num(s1_year == '0 ? '0 : prev_c[YEAR_W-1:2]), .quo(p100_c));
  dtdn_div25 u_div_p400 (.num({2'b00, prev_c[YEAR_W-1:4]}), .quo(p400_c));
  dtdn_div25 u_div_y100 (.num(s1_year[YEAR_W-1:2]), .quo(y100_c));
  dtdn_div25 u_div_y400 (.num({2'b00, s1_year[YEAR_W-1:4]}), .quo(y400_c));

  assign fields_ok_c = (s1_day != '0) && (s1_year != '0)
                    && ({3'b000, s1_year} <= YEAR_LIMIT)
                    && (s1_month >= MONTH_JAN) && (s1_month <= MONTH_DEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_day       <= s1_day;
      s2_month     <= s1_month;
      s2_year      <= s1_year;
      s2_prev      <= prev_c;
      s2_p100      <= p100_c;
      s2_p400      <= p400_c;
      s2_y100      <= y100_c;
      s2_y400      <= y400_c;
      s2_mlen_base <= month_days(s1_month);
      s2_doy_base  <= days_before(s1_month) + DOY_W'(s1_day);
      s2_fields_ok <= fields_ok_c;
    end
  end

  // ---------------- stage 3
  logic [12:0]        y100_x25, y400_x25;
  logic               div4_c, div100_c, div400_c, leap_c;
  logic [DAY_W-1:0]   mlen_c;
  logic               ok_c;
  logic [DOY_W-1:0]   doy_c;
  logic [22:0]        p365_c;
  logic [12:0]        corr_c;

  assign y100_x25 = (13'(s2_y100) << 4) + (13'(s2_y100) << 3) + 13'(s2_y100);
  assign y400_x25 = (13'(s2_y400) << 4) + (13'(s2_y400) << 3) + 13'(s2_y400);

  assign div4_c   = (s2_year[1:0] == 2'b00);
  assign div100_c = div4_c && ({1'b0, s2_year[YEAR_W-1:2]} == y100_x25);
  assign div400_c = (s2_year[3:0] == 4'b0000)
                 && ({3'b000, s2_year[YEAR_W-1:4]} == y400_x25);
  assign leap_c   = (div4_c && !div100_c) || div400_c;

  assign mlen_c = (s2_month == MONTH_FEB && leap_c) ? FEB_LEAP_DAYS : s2_mlen_base;
  assign ok_c   = s2_fields_ok && (s2_day <= mlen_c);
  assign doy_c  = s2_doy_base + DOY_W'(leap_c && (s2_month > MONTH_FEB));

  assign p365_c = 23'(s2_prev) * 23'(DAYS_PER_YEAR);
  // p/4 - p/100 + p/400, never negative
  assign corr_c = 13'(s2_prev[YEAR_W-1:2]) - 13'(s2_p100) + 13'(s2_p400);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_ok   <= ok_c;
      s3_leap <= leap_c;
      s3_mlen <= ok_c ? mlen_c : '0;
      s3_doy  <= ok_c ? doy_c : '0;
      s3_p365 <= p365_c[DNUM_W-1:0];
      s3_corr <= corr_c;
    end
  end

  // ---------------- output register
  logic [DNUM_W-1:0] dnum_c;

  assign dnum_c = s3_p365 + DNUM_W'(s3_corr) + DNUM_W'(s3_doy);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ok   <= s3_ok;
      out_leap <= s3_leap;
      out_mlen <= s3_mlen;
      out_doy  <= s3_doy;
      out_dnum <= s3_ok ? dnum_c : '0;
    end
  end

  assign day_out.valid        = out_vld;
  assign day_out.valid_res    = out_ok;
  assign day_out.leap_year    = out_leap;
  assign day_out.month_length = out_mlen;
  assign day_out.day_of_year  = out_doy;
  assign day_out.day_number   = out_dnum;

endmodule

`default_nettype wire

// ----- rtl/dtdn_checker.sv -----
// ----------------------------------------------------------------------------
// dtdn_checker
// Port-level checks on the date to day number block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtdn_checker
  import dtdn_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              valid_res,
  input wire logic              leap_year,
  input wire logic [DAY_W-1:0]  month_length,
  input wire logic [DOY_W-1:0]  day_of_year,
  input wire logic [DNUM_W-1:0] day_number
);

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(day_number)
      && $stable(valid_res) && $stable(day_of_year))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result pending right after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> month_length == '0 && day_of_year == '0
      && day_number == '0)
    else $error("invalid date with nonzero fields");

  a_valid_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> month_length >= 5'd28 && day_of_year != '0
      && day_number != '0 && {4'b0000, day_of_year} <= 13'(month_length) + 13'd335)
    else $error("valid date with out-of-range fields");

  a_feb29_leap: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res && month_length == FEB_LEAP_DAYS |-> leap_year)
    else $error("29-day month in a common year");

endmodule

bind date_to_day_number_top dtdn_checker u_dtdn_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (day_out.valid),
  .out_ready    (day_out.ready),
  .valid_res    (day_out.valid_res),
  .leap_year    (day_out.leap_year),
  .month_length (day_out.month_length),
  .day_of_year  (day_out.day_of_year),
  .day_number   (day_out.day_number)
);

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for date_to_day_number_top. A directed table of
// calendar corners is followed by random dates, mostly well-formed with
// some out-of-range noise. Every accepted request gets its expected result
// from a local Gregorian calculation, or from the table where the answer is
// written in. Both channels idle at random outside a quiet stretch of dates.
// ----------------------------------------------------------------------------

module tb;
  import dtdn_pkg::*;

  localparam int unsigned LAST_YEAR    = 9999;
  localparam int unsigned RANDOM_DATES = 400;
  localparam int unsigned QUIET_FIRST  = 200;
  localparam int unsigned QUIET_LAST   = 280;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned TABLE_ROWS   = 22;

  // common-year month lengths and days ahead of each month, entry 0 unused
  localparam int unsigned MONTH_LEN [13] =
    '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int unsigned DAYS_AHEAD [13] =
    '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct packed {
    logic              valid_res;
    logic              leap_year;
    logic [DAY_W-1:0]  month_length;
    logic [DOY_W-1:0]  day_of_year;
    logic [DNUM_W-1:0] day_number;
  } day_result_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               typed;
    day_result_t        want;
  } date_row_t;

  logic clk;
  logic rst;
  logic quiet_run;

  day_result_t pending_days [$];
  int unsigned cycle_count;
  int unsigned mismatch_count;
  int unsigned dates_sent;
  int unsigned results_checked;
  int unsigned valid_dates_seen;

  dtdn_date_if   date_ch ();
  dtdn_result_if res_ch ();

  date_to_day_number_top #(
    .YEAR_MAX (LAST_YEAR)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .date_in (date_ch),
    .day_out (res_ch)
  );

  date_row_t date_table [TABLE_ROWS] = '{
    '{5'd1,  4'd1,  14'd1,     1'b1, '{1'b1, 1'b0, 5'd31, 9'd1,   22'd1}},
    '{5'd31, 4'd12, 14'd9999,  1'b1, '{1'b1, 1'b0, 5'd31, 9'd365, 22'd3652059}},
    '{5'd0,  4'd1,  14'd1,     1'b1, '{1'b0, 1'b0, 5'd0,  9'd0,   22'd0}},
    '{5'd1,  4'd0,  14'd1,     1'b1, '{1'b0, 1'b0, 5'd0,  9'd0,   22'd0}},
    '{5'd1,  4'd13, 14'd2000,  1'b1, '{1'b0, 1'b1, 5'd0,  9'd0,   22'd0}},
    '{5'd31, 4'd15, 14'd16383, 1'b1, '{1'b0, 1'b0, 5'd0,  9'd0,   22'd0}},
    '{5'd1,  4'd1,  14'd0,     1'b1, '{1'b0, 1'b1, 5'd0,  9'd0,   22'd0}},
    '{5'd0,  4'd0,  14'd0,     1'b1, '{1'b0, 1'b1, 5'd0,  9'd0,   22'd0}},
    '{5'd1,  4'd1,  14'd10000, 1'b1, '{1'b0, 1'b1, 5'd0,  9'd0,   22'd0}},
    '{5'd29, 4'd2,  14'd1900,  1'b1, '{1'b0, 1'b0, 5'd0,  9'd0,   22'd0}},
    '{5'd30, 4'd2,  14'd2000,  1'b1, '{1'b0, 1'b1, 5'd0,  9'd0,   22'd0}},
    '{5'd31, 4'd4,  14'd2021,  1'b1, '{1'b0, 1'b0, 5'd0,  9'd0,   22'd0}},
    '{5'd29, 4'd2,  14'd2000,  1'b0, '0},
    '{5'd28, 4'd2,  14'd2100,  1'b0, '0},
    '{5'd29, 4'd2,  14'd2004,  1'b0, '0},
    '{5'd30, 4'd4,  14'd2021,  1'b0, '0},
    '{5'd31, 4'd12, 14'd2000,  1'b0, '0},
    '{5'd1,  4'd3,  14'd2400,  1'b0, '0},
    '{5'd15, 4'd6,  14'd1582,  1'b0, '0},
    '{5'd31, 4'd1,  14'd9999,  1'b0, '0},
    '{5'd31, 4'd12, 14'd1,     1'b0, '0},
    '{5'd28, 4'd2,  14'd9999,  1'b0, '0}
  };

  function automatic day_result_t predict_day_number(
    input logic [DAY_W-1:0]   d,
    input logic [MONTH_W-1:0] m,
    input logic [YEAR_W-1:0]  y
  );
    day_result_t r;
    bit          leap;
    bit          month_ok;
    int unsigned mlen;
    int unsigned doy;
    int unsigned prior;
    r        = '0;
    mlen     = 0;
    leap     = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    month_ok = (m >= MONTH_JAN) && (m <= MONTH_DEC);
    r.leap_year = leap;
    if (month_ok) begin
      mlen = MONTH_LEN[m];
      if (m == MONTH_FEB && leap) mlen = 32'(FEB_LEAP_DAYS);
    end
    if (d >= 1 && y >= 1 && y <= LAST_YEAR && month_ok && d <= mlen) begin
      doy   = DAYS_AHEAD[m] + 32'(d) + ((leap && m > MONTH_FEB) ? 1 : 0);
      prior = 32'(y) - 1;
      r.valid_res    = 1'b1;
      r.month_length = mlen[DAY_W-1:0];
      r.day_of_year  = doy[DOY_W-1:0];
      r.day_number   = DNUM_W'(prior * 365 + prior / 4 - prior / 100 + prior / 400 + doy);
    end
    return r;
  endfunction

  // hold the request until taken, then queue what the result must be
  task automatic send_date(
    input logic [DAY_W-1:0]   d,
    input logic [MONTH_W-1:0] m,
    input logic [YEAR_W-1:0]  y,
    input logic               typed,
    input day_result_t        want
  );
    while (!quiet_run && $urandom_range(0, 99) < 38) begin
      date_ch.valid <= 1'b0;
      @(negedge clk);
    end
    date_ch.valid <= 1'b1;
    date_ch.day   <= d;
    date_ch.month <= m;
    date_ch.year  <= y;
    @(posedge clk);
    while (!date_ch.ready) @(posedge clk);
    pending_days.push_back(typed ? want : predict_day_number(d, m, y));
    dates_sent++;
    @(negedge clk);
  endtask

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_ch.ready <= quiet_run || ($urandom_range(0, 99) >= 38);
  end

  always @(posedge clk) begin
    day_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_days.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_days.pop_front();
        results_checked++;
        if (want.valid_res) valid_dates_seen++;
        if (res_ch.valid_res !== want.valid_res) begin
          $error("valid_res: expected %0d, got %0d", want.valid_res, res_ch.valid_res);
          mismatch_count++;
        end
        if (res_ch.leap_year !== want.leap_year) begin
          $error("leap_year: expected %0d, got %0d", want.leap_year, res_ch.leap_year);
          mismatch_count++;
        end
        if (res_ch.month_length !== want.month_length) begin
          $error("month_length: expected %0d, got %0d", want.month_length,
                 res_ch.month_length);
          mismatch_count++;
        end
        if (res_ch.day_of_year !== want.day_of_year) begin
          $error("day_of_year: expected %0d, got %0d", want.day_of_year,
                 res_ch.day_of_year);
          mismatch_count++;
        end
        if (res_ch.day_number !== want.day_number) begin
          $error("day_number: expected %0d, got %0d", want.day_number,
                 res_ch.day_number);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [DAY_W-1:0]   d;
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;
    int unsigned        mlen;
    int unsigned        pick;
    day_result_t        probe;
    rst              = 1'b1;
    quiet_run        = 1'b0;
    cycle_count      = 0;
    mismatch_count   = 0;
    dates_sent       = 0;
    results_checked  = 0;
    valid_dates_seen = 0;
    date_ch.valid    = 1'b0;
    date_ch.day      = '0;
    date_ch.month    = '0;
    date_ch.year     = '0;
    res_ch.ready     = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (date_table[i]) begin
      send_date(date_table[i].day, date_table[i].month, date_table[i].year,
                date_table[i].typed, date_table[i].want);
    end

    for (int unsigned n = 0; n < RANDOM_DATES; n++) begin
      quiet_run = (n >= QUIET_FIRST) && (n < QUIET_LAST);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        // raw noise across every field bit
        d = DAY_W'($urandom_range(0, 31));
        m = MONTH_W'($urandom_range(0, 15));
        y = YEAR_W'($urandom_range(0, 16383));
      end else begin
        case ($urandom_range(0, 7))
          0:       y = YEAR_W'($urandom_range(1, 4));
          1:       y = YEAR_W'($urandom_range(LAST_YEAR - 3, LAST_YEAR));
          2:       y = YEAR_W'($urandom_range(1, 99) * 100 + $urandom_range(0, 2) - 1);
          default: y = YEAR_W'($urandom_range(1, LAST_YEAR));
        endcase
        m     = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
        probe = predict_day_number(5'd1, m, y);
        mlen  = 32'(probe.month_length);
        if (pick == 2 && mlen < 31) begin
          d = DAY_W'($urandom_range(mlen + 1, 31));   // one past the month end or more
        end else if (pick == 3) begin
          d = DAY_W'($urandom_range(mlen - 1, mlen));
        end else begin
          d = DAY_W'($urandom_range(1, mlen));
        end
      end
      send_date(d, m, y, 1'b0, '0);
    end
    quiet_run = 1'b0;
    date_ch.valid <= 1'b0;

    while (pending_days.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d dates sent (%0d from the table), %0d results checked,",
             dates_sent, TABLE_ROWS, results_checked);
    $display("summary: %0d real calendar dates, %0d mismatches, %0d cycles",
             valid_dates_seen, mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
